[rtl/core/ecwd_pkg.sv]
// Package for the event camera word decoder.
// Holds the word codes, register indexes and the pixel-group queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package ecwd_pkg;

  // Word codes, bits 14..12 of a non-timestamp word.
  localparam logic [2:0] CODE_CONTROL   = 3'd0;
  localparam logic [2:0] CODE_COLUMN    = 3'd1;
  localparam logic [2:0] CODE_GROUP_TWO = 3'd2;
  localparam logic [2:0] CODE_GROUP_ONE = 3'd3;
  localparam logic [2:0] CODE_BASES     = 3'd4;
  localparam logic [2:0] CODE_WRAP      = 3'd7;

  // Control word data that restarts the time base.
  localparam logic [11:0] CONTROL_TIME_RESET = 12'd1;

  // Column value that stands for column zero.
  localparam logic [9:0] COLUMN_ZERO_ALIAS = 10'h3FF;

  // Configuration register indexes.
  localparam logic [1:0] REG_SENSOR_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SENSOR_HEIGHT = 2'd1;

  localparam logic [10:0] SENSOR_WIDTH_RESET  = 11'd640;
  localparam logic [10:0] SENSOR_HEIGHT_RESET = 11'd480;

  // One pixel-group word after classification: the surviving mask bits only.
  typedef struct packed {
    logic [47:0]        rel_time;
    logic [9:0]         pixel_x;
    logic signed [10:0] row_base;
    logic [7:0]         mask;
    logic               polarity;
  } group_t;

endpackage

[rtl/core/ecwd_front.sv]
// Front end of the event camera word decoder: accepts words, keeps the time,
// column and row-group state, and queues filtered pixel-group words.
// Depends on ecwd_pkg.
`timescale 1ns / 1ps

module ecwd_front #(
  parameter int TIME_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               event_valid,
  output logic               event_ready,
  input  logic [15:0]        event_word,
  input  logic               q_full,
  output logic               q_push,
  output ecwd_pkg::group_t   q_data
);
  import ecwd_pkg::*;

  logic [10:0]          sensor_width;
  logic [10:0]          sensor_height;
  logic                 time_started;
  logic [TIME_BITS-1:0] wrap_offset;
  logic [TIME_BITS-1:0] first_time;
  logic [TIME_BITS-1:0] current_time;
  logic [9:0]           column_latch;
  logic [9:0]           group_one_row;
  logic signed [10:0]   group_two_row;

  logic                 accept;
  logic [2:0]           code;
  logic [11:0]          data;
  logic                 is_time;
  logic [TIME_BITS-1:0] stamp_time;
  logic [TIME_BITS-1:0] wrap_next;
  logic [TIME_BITS-1:0] rel_full;
  logic [63:0]          rel_wide;
  logic [5:0]           g1;
  logic [4:0]           off;
  logic signed [7:0]    g2;
  logic signed [10:0]   base;
  logic                 x_ok;
  logic [7:0]           keep;

  assign event_ready = !q_full;
  assign accept      = event_valid && event_ready;
  assign is_time     = event_word[15];
  assign code        = event_word[14:12];
  assign data        = event_word[11:0];

  // Time candidates for a timestamp word and for a wrap word.
  assign stamp_time = wrap_offset + TIME_BITS'(event_word[14:0]);
  assign wrap_next  = wrap_offset + TIME_BITS'({data, 15'd0});

  // Relative time, reduced to the time width and then to the 48-bit field.
  assign rel_full = current_time - first_time;
  assign rel_wide = 64'(rel_full);

  // Row-group bases from a base word.
  assign g1  = data[5:0];
  assign off = data[10:6];
  assign g2  = data[11] ? (8'(g1) - 8'(off)) : (8'(g1) + 8'(off));

  // Filter each mask bit against the sensor size.
  assign base = (code == CODE_GROUP_ONE) ? $signed({1'b0, group_one_row}) : group_two_row;
  assign x_ok = {1'b0, column_latch} < sensor_width;

  always_comb begin
    logic signed [11:0] y;
    for (int i = 0; i < 8; i++) begin
      y = 12'(base) + 12'(i);
      keep[i] = data[i] && x_ok && !y[11] && (y < $signed({1'b0, sensor_height}));
    end
  end

  assign q_push = accept && !is_time && time_started && (keep != 8'd0) &&
                  ((code == CODE_GROUP_ONE) || (code == CODE_GROUP_TWO));

  always_comb begin
    q_data.rel_time = rel_wide[47:0];
    q_data.pixel_x  = column_latch;
    q_data.row_base = base;
    q_data.mask     = keep;
    q_data.polarity = !data[8];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_width  <= SENSOR_WIDTH_RESET;
      sensor_height <= SENSOR_HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_SENSOR_WIDTH) begin
        sensor_width <= cfg_data;
      end
      if (cfg_index == REG_SENSOR_HEIGHT) begin
        sensor_height <= cfg_data;
      end
    end
  end

  // Decoder state update for each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_started  <= 1'b0;
      wrap_offset   <= '0;
      first_time    <= '0;
      current_time  <= '0;
      column_latch  <= '0;
      group_one_row <= '0;
      group_two_row <= '0;
    end else if (accept) begin
      if (is_time) begin
        current_time <= stamp_time;
        if (!time_started) begin
          first_time   <= stamp_time;
          time_started <= 1'b1;
        end
      end else begin
        unique case (code)
          CODE_CONTROL: begin
            if (data == CONTROL_TIME_RESET) begin
              wrap_offset   <= '0;
              time_started  <= 1'b0;
              current_time  <= '0;
              column_latch  <= '0;
              group_one_row <= '0;
              group_two_row <= '0;
            end
          end
          CODE_COLUMN: begin
            column_latch <= (data[9:0] == COLUMN_ZERO_ALIAS) ? 10'd0 : data[9:0];
          end
          CODE_BASES: begin
            group_one_row <= {1'b0, g1, 3'd0};
            group_two_row <= {g2, 3'd0};
          end
          CODE_WRAP: begin
            wrap_offset  <= wrap_next;
            current_time <= wrap_next;
            if (!time_started) begin
              first_time   <= wrap_next;
              time_started <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[rtl/core/ecwd_fifo.sv]
// Short queue of pixel-group entries between the front and back ends.
// Depends on ecwd_pkg.
`timescale 1ns / 1ps

module ecwd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ecwd_pkg::group_t push_data,
  input  logic             pop,
  output ecwd_pkg::group_t pop_data,
  output logic             full,
  output logic             empty
);
  import ecwd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  group_t        entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/ecwd_back.sv]
// Back end of the event camera word decoder: expands one queued pixel-group
// entry into pixel events, lowest mask bit first, through an output register.
// Depends on ecwd_pkg.
`timescale 1ns / 1ps

module ecwd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  ecwd_pkg::group_t   q_data,
  output logic               q_pop,
  output logic               pixel_valid,
  input  logic               pixel_ready,
  output logic signed [47:0] rel_time,
  output logic [9:0]         pixel_x,
  output logic [9:0]         pixel_y,
  output logic               polarity,
  output logic               last_of_word
);
  import ecwd_pkg::*;

  group_t             work;
  logic               busy;
  logic               advance;
  logic               is_last;
  logic               free;
  logic [2:0]         bit_index;
  logic [7:0]         mask_rest;
  logic signed [10:0] row;

  // Lowest set bit of the remaining mask.
  always_comb begin
    bit_index = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (work.mask[i]) begin
        bit_index = 3'(i);
      end
    end
  end

  assign mask_rest = work.mask & (work.mask - 8'd1);
  assign is_last   = (mask_rest == 8'd0);
  assign advance   = busy && (!pixel_valid || pixel_ready);
  assign free      = !busy || (advance && is_last);
  assign q_pop     = free && !q_empty;
  assign row       = work.row_base + 11'(bit_index);

  // Working entry: load from the queue, or drop the bit just emitted.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (advance && is_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work <= q_data;
    end else if (advance) begin
      work.mask <= mask_rest;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (advance) begin
      pixel_valid <= 1'b1;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rel_time     <= $signed(work.rel_time);
      pixel_x      <= work.pixel_x;
      pixel_y      <= row[9:0];
      polarity     <= work.polarity;
      last_of_word <= is_last;
    end
  end

endmodule

[rtl/core/event_camera_word_decoder.sv]
// Top level of the event camera word decoder.
// Depends on ecwd_pkg, ecwd_front, ecwd_fifo and ecwd_back.
//
//   Port group     Direction  Handshake              Payload
//   event word     in         event_valid/ready      event_word
//   pixel event    out        pixel_valid/ready      rel_time, pixel_x, pixel_y,
//                                                    polarity, last_of_word
//   configuration  in         cfg_write              cfg_index, cfg_data
//
// One word is accepted per cycle while the four-entry group queue has room.
// A pixel-group word yields up to eight events, one per cycle from the back
// end while pixel_ready is high, so the event output sets the rate when groups are dense.
// The first event of a word is registered in a queue entry, then in the back
// end's working entry and then in the output register on its way out.
// Reset is synchronous; it restores the sensor size to 640 by 480 and clears
// all time, column and row-group state. Either side may stall independently.
`timescale 1ns / 1ps

module event_camera_word_decoder #(
  parameter int TIME_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  logic               event_valid,
  output logic               event_ready,
  input  logic [15:0]        event_word,
  output logic               pixel_valid,
  input  logic               pixel_ready,
  output logic signed [47:0] rel_time,
  output logic [9:0]         pixel_x,
  output logic [9:0]         pixel_y,
  output logic               polarity,
  output logic               last_of_word
);
  import ecwd_pkg::*;

  localparam int QUEUE_DEPTH = 4;

  group_t push_data;
  group_t pop_data;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  // Word intake and classification.
  ecwd_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_word  (event_word),
    .q_full      (full),
    .q_push      (push),
    .q_data      (push_data)
  );

  // Queue of pending pixel groups.
  ecwd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // Event expansion and output register.
  ecwd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (empty),
    .q_data       (pop_data),
    .q_pop        (pop),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .rel_time     (rel_time),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .polarity     (polarity),
    .last_of_word (last_of_word)
  );

endmodule

[rtl/core/ecwd_checker.sv]
// Port-level checks for the event camera word decoder, bound to the top level.
// Depends on event_camera_word_decoder.
`timescale 1ns / 1ps

module ecwd_checker (
  input logic               clk,
  input logic               rst,
  input logic               pixel_valid,
  input logic               pixel_ready,
  input logic signed [47:0] rel_time,
  input logic [9:0]         pixel_x,
  input logic               polarity,
  input logic               last_of_word
);

  // No event is offered right after reset.
  assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel event offered after reset");

  // A stalled event holds its time, column and polarity.
  assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !pixel_ready) |=> (pixel_valid && $stable(rel_time) &&
                                       $stable(pixel_x) && $stable(polarity)))
    else $error("stalled pixel event changed");

  // Events of one word follow without a gap and share time, column and polarity.
  assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && pixel_ready && !last_of_word) |=>
      (pixel_valid && $stable(rel_time) && $stable(pixel_x) && $stable(polarity)))
    else $error("events of one word broken apart");

  // The all-ones column code never leaves the decoder.
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> (pixel_x != 10'h3FF))
    else $error("column alias leaked to output");

endmodule

bind event_camera_word_decoder ecwd_checker u_checker (.*);
